// ----- sv/fisr_pkg.sv -----
package fisr_pkg;

    localparam logic [31:0] MAGIC_CONST  = 32'h5F3759DF;
    localparam logic [31:0] CANON_NAN    = 32'h7FC00000;
    localparam logic [31:0] FP_ONE_HALF  = 32'h3F000000;
    localparam logic [31:0] FP_THREE_HLF = 32'h3FC00000;
    localparam logic [31:0] FP_INF_MAG   = 32'h7F800000;

    // Unrounded operation result handed from an arithmetic front end to the rounder.
    // Value is mag * 2^(exp_b - 127 - 47) unless special is set.
    typedef struct packed {
        logic               special;
        logic [31:0]        spec_val;
        logic               sign;
        logic signed [10:0] exp_b;
        logic [47:0]        mag;
    } t_rnd_in;

endpackage

// ----- sv/fisr_round.sv -----
module fisr_round (
    input  fisr_pkg::t_rnd_in i_in,
    output logic [31:0]       o_res
);
    import fisr_pkg::*;

    logic [5:0]         lz;
    logic signed [10:0] e0;
    logic signed [10:0] eb_m1;
    logic signed [10:0] rs;
    logic [47:0]        q;
    logic [95:0]        wide;
    logic               st_x;
    logic [7:0]         expf;
    logic               rnd;
    logic [30:0]        body;

    always_comb begin
        lz = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (i_in.mag[i]) begin
                lz = 6'(47 - i);
            end
        end
    end

    assign e0    = i_in.exp_b - $signed({5'b0, lz});
    assign eb_m1 = i_in.exp_b - 11'sd1;
    assign rs    = 11'sd1 - i_in.exp_b;

    always_comb begin
        q    = '0;
        st_x = 1'b0;
        expf = 8'd0;
        wide = '0;
        if (e0 >= 11'sd1) begin
            q    = i_in.mag << lz;
            expf = e0[7:0];
        end else if (i_in.exp_b >= 11'sd1) begin
            q = i_in.mag << eb_m1[5:0];
        end else if (rs > 11'sd48) begin
            st_x = |i_in.mag;
        end else begin
            wide = {i_in.mag, 48'd0} >> rs[5:0];
            q    = wide[95:48];
            st_x = |wide[47:0];
        end
    end

    assign rnd  = q[23] & (st_x | (|q[22:0]) | q[24]);
    assign body = {expf, q[46:24]} + {30'd0, rnd};

    always_comb begin
        if (i_in.special) begin
            o_res = i_in.spec_val;
        end else if (i_in.mag == '0) begin
            o_res = {i_in.sign, 31'd0};
        end else if (e0 >= 11'sd255) begin
            o_res = {i_in.sign, FP_INF_MAG[30:0]};
        end else begin
            o_res = {i_in.sign, body};
        end
    end

endmodule

// ----- sv/fisr_fmul.sv -----
module fisr_fmul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res
);
    import fisr_pkg::*;

    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    t_rnd_in     n_mid, r_mid;
    logic [31:0] n_res;

    assign ea     = i_a[30:23];
    assign eb     = i_b[30:23];
    assign ma     = {ea != 8'd0, i_a[22:0]};
    assign mb     = {eb != 8'd0, i_b[22:0]};
    assign a_nan  = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
    assign b_nan  = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
    assign a_inf  = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
    assign b_inf  = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
    assign a_zero = i_a[30:0] == 31'd0;
    assign b_zero = i_b[30:0] == 31'd0;
    assign sgn    = i_a[31] ^ i_b[31];

    always_comb begin
        n_mid.sign  = sgn;
        n_mid.mag   = ma * mb;
        n_mid.exp_b = $signed({3'b0, (ea == 8'd0) ? 8'd1 : ea})
                    + $signed({3'b0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd126;
        n_mid.special  = 1'b1;
        n_mid.spec_val = CANON_NAN;
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            n_mid.spec_val = CANON_NAN;
        end else if (a_inf || b_inf) begin
            n_mid.spec_val = {sgn, FP_INF_MAG[30:0]};
        end else if (a_zero || b_zero) begin
            n_mid.spec_val = {sgn, 31'd0};
        end else begin
            n_mid.special = 1'b0;
        end
    end

    // Product and exponent are registered before normalization and rounding.
    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
        o_res <= n_res;
    end

    fisr_round u_round (
        .i_in  (r_mid),
        .o_res (n_res)
    );

endmodule

// ----- sv/fisr_fsub.sv -----
module fisr_fsub (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_res
);
    import fisr_pkg::*;

    logic [31:0] nb, big, sml;
    logic        a_nan, b_nan, a_inf, b_inf;
    logic [7:0]  e_big, e_sml, d;
    logic [26:0] x_big, x_sml, sh, al;
    logic        lost;
    logic [27:0] sum;
    t_rnd_in     n_mid, r_mid;
    logic [31:0] n_res;

    assign nb    = {~i_b[31], i_b[30:0]};
    assign a_nan = (i_a[30:23] == 8'hFF) && (i_a[22:0] != 23'd0);
    assign b_nan = (i_b[30:23] == 8'hFF) && (i_b[22:0] != 23'd0);
    assign a_inf = (i_a[30:23] == 8'hFF) && (i_a[22:0] == 23'd0);
    assign b_inf = (i_b[30:23] == 8'hFF) && (i_b[22:0] == 23'd0);

    assign big   = (i_a[30:0] >= nb[30:0]) ? i_a : nb;
    assign sml   = (i_a[30:0] >= nb[30:0]) ? nb : i_a;
    assign e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    assign e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    assign d     = e_big - e_sml;
    assign x_big = {big[30:23] != 8'd0, big[22:0], 3'b000};
    assign x_sml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};

    always_comb begin
        sh   = '0;
        lost = 1'b0;
        if (d >= 8'd27) begin
            al = {26'd0, |x_sml};
        end else begin
            sh   = x_sml >> d[4:0];
            lost = |(x_sml & ((27'd1 << d[4:0]) - 27'd1));
            al   = sh | {26'd0, lost};
        end
    end

    assign sum = (big[31] == sml[31]) ? ({1'b0, x_big} + {1'b0, al})
                                      : ({1'b0, x_big} - {1'b0, al});

    always_comb begin
        n_mid.mag   = {sum, 20'd0};
        n_mid.exp_b = $signed({3'b0, e_big}) + 11'sd1;
        // An exact cancellation gives +0 unless a and the negated b are both negative zeros.
        n_mid.sign  = (sum == 28'd0) ? (big[31] & sml[31]) : big[31];
        n_mid.special  = 1'b1;
        n_mid.spec_val = CANON_NAN;
        if (a_nan || b_nan || (a_inf && b_inf && (i_a[31] != nb[31]))) begin
            n_mid.spec_val = CANON_NAN;
        end else if (a_inf) begin
            n_mid.spec_val = i_a;
        end else if (b_inf) begin
            n_mid.spec_val = nb;
        end else begin
            n_mid.special = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mid <= n_mid;
        o_res <= n_res;
    end

    fisr_round u_round (
        .i_in  (r_mid),
        .o_res (n_res)
    );

endmodule

// ----- sv/fast_inverse_square_root.sv -----
// Fast inverse square root: a fully pipelined binary32 unit that takes one operand per
// clock and returns one result per clock. busy never rises, so start may be held high
// continuously. The pipeline consists of the input register, nine floating-point
// operations of two stages each, and the output register. The result strobe lasts one
// cycle and cannot be held off, so a receiver must take every result as it comes. The
// step count register (1 or 2 Newton steps; 0 acts as 1 and 3 as 2) is sampled per item
// at the start transfer, and a config transfer is always ready. Any NaN result is
// delivered as 0x7FC00000.
module fast_inverse_square_root (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_operand_bits,
    output logic        o_result_valid,
    output logic [31:0] o_result_bits,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_newton_steps
);
    import fisr_pkg::*;

    // Delay lines are tapped at fixed places matching the latency of each unit.
    localparam int VLD_DEPTH = 18;

    logic [1:0]  r_steps;
    logic        r_in_vld, r_in_two;
    logic [31:0] r_in_x, r_in_y0;
    logic [VLD_DEPTH-1:0] r_vld, r_two;
    logic [31:0] r_y0 [0:7];
    logic [31:0] r_hx [0:7];
    logic [31:0] r_r1 [0:7];
    logic [31:0] hx, t0a, t1a, t2a, r1, t0b, t1b, t2b, r2;
    logic [31:0] n_res;
    logic [31:0] shifted;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= 2'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_steps <= i_cfg_newton_steps;
        end
    end

    // The initial estimate is the magic constant minus the operand shifted right with
    // sign fill, taken modulo 2^32.
    assign shifted = {i_operand_bits[31], i_operand_bits[31:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_vld    <= '0;
        end else begin
            r_in_vld <= start && !busy;
            r_vld    <= {r_vld[VLD_DEPTH-2:0], r_in_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_x   <= i_operand_bits;
        r_in_y0  <= MAGIC_CONST - shifted;
        // Only the upper bit matters: codes 2 and 3 run two steps, 0 and 1 run one.
        r_in_two <= r_steps[1];
        r_two    <= {r_two[VLD_DEPTH-2:0], r_in_two};
        r_y0[0]  <= r_in_y0;
        r_hx[0]  <= hx;
        r_r1[0]  <= r1;
        for (int i = 1; i < 8; i++) begin
            r_y0[i] <= r_y0[i-1];
            r_hx[i] <= r_hx[i-1];
            r_r1[i] <= r_r1[i-1];
        end
    end

    // First Newton step.
    fisr_fmul u_half (.i_clk(i_clk), .i_a(r_in_x),       .i_b(FP_ONE_HALF), .o_res(hx));
    fisr_fmul u_t0a  (.i_clk(i_clk), .i_a(hx),           .i_b(r_y0[1]),     .o_res(t0a));
    fisr_fmul u_t1a  (.i_clk(i_clk), .i_a(t0a),          .i_b(r_y0[3]),     .o_res(t1a));
    fisr_fsub u_t2a  (.i_clk(i_clk), .i_a(FP_THREE_HLF), .i_b(t1a),         .o_res(t2a));
    fisr_fmul u_r1   (.i_clk(i_clk), .i_a(r_y0[7]),      .i_b(t2a),         .o_res(r1));

    // Second Newton step.
    fisr_fmul u_t0b  (.i_clk(i_clk), .i_a(r_hx[7]),      .i_b(r1),          .o_res(t0b));
    fisr_fmul u_t1b  (.i_clk(i_clk), .i_a(t0b),          .i_b(r_r1[1]),     .o_res(t1b));
    fisr_fsub u_t2b  (.i_clk(i_clk), .i_a(FP_THREE_HLF), .i_b(t1b),         .o_res(t2b));
    fisr_fmul u_r2   (.i_clk(i_clk), .i_a(r_r1[5]),      .i_b(t2b),         .o_res(r2));

    always_comb begin
        n_res = r_two[VLD_DEPTH-1] ? r2 : r_r1[7];
        if ((n_res[30:23] == 8'hFF) && (n_res[22:0] != 23'd0)) begin
            n_res = CANON_NAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= r_vld[VLD_DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_result_bits <= n_res;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##20 o_result_valid)
        else $error("result transfer missing after fixed latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_vld[VLD_DEPTH-1]))
        else $error("result strobe without an item in the pipeline");

    a_canon_nan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result_bits[30:23] == 8'hFF) && (o_result_bits[22:0] != 23'd0))
        |-> (o_result_bits == CANON_NAN))
        else $error("non-canonical NaN on result port");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Checks the pipelined reciprocal square root unit. A binary32 model of the
// magic-constant estimate and Newton steps, with round-to-nearest-even, predicts
// every result. The run has a directed table first, then random operands under
// each step count setting. Start and the config write channel idle at random.
module testbench;
    import fisr_pkg::*;

    localparam int CLK_HALF   = 6;
    localparam int LATENCY    = 20;
    localparam int CYCLE_CAP  = 400000;
    localparam int ITEMS_EACH = 220;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_operand_bits;
    logic        o_result_valid;
    logic [31:0] o_result_bits;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_newton_steps;

    fast_inverse_square_root DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operand_bits     (i_operand_bits),
        .o_result_valid     (o_result_valid),
        .o_result_bits      (o_result_bits),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_newton_steps (i_cfg_newton_steps)
    );

    always begin
        i_clk = 1'b1;
        #CLK_HALF;
        i_clk = 1'b0;
        #CLK_HALF;
    end

    // Mirror of the step count register, and the results still owed by the unit.
    logic [1:0]  steps_mirror;
    logic [31:0] rsqrt_pending[$];
    int          mismatch_count;
    int          cycle_count;
    int          result_count;
    int          sent_count;

    // Directed rows: an expected value is typed in only where it is obvious.
    typedef struct {
        logic [31:0] operand;
        logic        typed;
        logic [31:0] want;
    } t_stim_row;

    function automatic logic fp_is_nan(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 23'd0;
    endfunction

    function automatic logic fp_is_inf(logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] == 23'd0;
    endfunction

    // Significand and exponent such that the value is sig * 2^(ex - 150).
    function automatic void fp_unpack(input logic [31:0] v, output logic [23:0] sig,
                                      output int ex);
        sig = (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
        ex  = (v[30:23] == 8'd0) ? 1 : int'(v[30:23]);
    endfunction

    // Rounds sign * mag * 2^scale to binary32, nearest even; mag is nonzero.
    function automatic logic [31:0] fp_round(logic sgn, int scale, logic [127:0] mag);
        int           msb;
        int           ex;
        int           sh;
        logic [127:0] kept;
        logic [127:0] rest;
        logic [127:0] half;
        msb = 127;
        while (!mag[msb]) msb--;
        ex = msb + scale + 127;
        sh = (ex >= 1) ? msb - 23 : -149 - scale;
        if (sh > 120) return {sgn, 31'd0};
        if (sh > 0) begin
            kept = mag >> sh;
            rest = mag & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rest > half || (rest == half && kept[0])) kept = kept + 128'd1;
        end else begin
            kept = mag << (-sh);
        end
        if (ex >= 1) begin
            if (kept[24]) begin
                kept = kept >> 1;
                ex++;
            end
            if (ex >= 255) return {sgn, 8'hFF, 23'd0};
            return {sgn, ex[7:0], kept[22:0]};
        end
        // Subnormal; a carry into bit 23 lands on the smallest normal by itself.
        return {sgn, kept[30:0]};
    endfunction

    function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
        logic        sgn;
        logic [23:0] sa;
        logic [23:0] sb;
        int          ea;
        int          eb;
        sgn = a[31] ^ b[31];
        if (fp_is_nan(a) || fp_is_nan(b)) return CANON_NAN;
        if (fp_is_inf(a) || fp_is_inf(b)) begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return CANON_NAN;
            return {sgn, FP_INF_MAG[30:0]};
        end
        if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return {sgn, 31'd0};
        fp_unpack(a, sa, ea);
        fp_unpack(b, sb, eb);
        return fp_round(sgn, ea + eb - 300, 128'(sa) * 128'(sb));
    endfunction

    function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
        logic [23:0]  sa;
        logic [23:0]  sb;
        int           ea;
        int           eb;
        int           gap;
        logic [127:0] big;
        logic [127:0] tiny;
        logic         sbig;
        logic         stiny;
        if (fp_is_nan(a) || fp_is_nan(b)) return CANON_NAN;
        if (fp_is_inf(a) && fp_is_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
        if (fp_is_inf(a)) return a;
        if (fp_is_inf(b)) return b;
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 31'd0) return b;
        if (b[30:0] == 31'd0) return a;
        fp_unpack(a, sa, ea);
        fp_unpack(b, sb, eb);
        if (eb > ea) begin
            {sa, sb} = {sb, sa};
            {ea, eb} = {eb, ea};
            sbig  = b[31];
            stiny = a[31];
        end else begin
            sbig  = a[31];
            stiny = b[31];
        end
        // Forty guard bits; anything shifted further only matters as a sticky bit.
        gap  = ea - eb;
        big  = 128'(sa) << 40;
        tiny = (gap <= 40) ? (128'(sb) << (40 - gap)) : 128'd1;
        if (sbig == stiny) return fp_round(sbig, ea - 190, big + tiny);
        if (big == tiny) return 32'd0;
        if (big > tiny) return fp_round(sbig, ea - 190, big - tiny);
        return fp_round(stiny, ea - 190, tiny - big);
    endfunction

    function automatic logic [31:0] newton_refine(logic [31:0] y, logic [31:0] half_x);
        logic [31:0] prod;
        prod = fp_mul(fp_mul(half_x, y), y);
        return fp_mul(y, fp_add(FP_THREE_HLF, {~prod[31], prod[30:0]}));
    endfunction

    function automatic logic [31:0] rsqrt_predict(logic [31:0] x, logic [1:0] steps);
        logic [31:0] half_x;
        logic [31:0] y;
        half_x = fp_mul(x, FP_ONE_HALF);
        y      = MAGIC_CONST - {x[31], x[31:1]};
        y      = newton_refine(y, half_x);
        if (steps >= 2'd2) y = newton_refine(y, half_x);
        return fp_is_nan(y) ? CANON_NAN : y;
    endfunction

    // Every transfer is seen here at the rising edge: config writes update the
    // mirror, operand transfers queue a prediction, and result strobes are checked.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (o_result_valid) begin
                result_count <= result_count + 1;
                if (rsqrt_pending.size() == 0) begin
                    $error("result_bits: none expected, actual %h", o_result_bits);
                    mismatch_count <= mismatch_count + 1;
                end else if (o_result_bits !== rsqrt_pending[0]) begin
                    $error("result_bits: expected %h, actual %h",
                           rsqrt_pending[0], o_result_bits);
                    mismatch_count <= mismatch_count + 1;
                    void'(rsqrt_pending.pop_front());
                end else begin
                    void'(rsqrt_pending.pop_front());
                end
            end
            if (start && !busy) begin
                rsqrt_pending.push_back(rsqrt_predict(i_operand_bits, steps_mirror));
                sent_count <= sent_count + 1;
            end
            if (i_cfg_valid && o_cfg_ready) steps_mirror <= i_cfg_newton_steps;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_operand(logic [31:0] op);
        start          <= 1'b1;
        i_operand_bits <= op;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic maybe_idle(logic quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 55) return;
        start <= 1'b0;
        if (pick < 92) repeat ($urandom_range(1, 3)) @(negedge i_clk);
        else repeat ($urandom_range(10, 40)) @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (rsqrt_pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_steps(logic [1:0] steps);
        drain_results();
        repeat (LATENCY + 2) @(negedge i_clk);
        repeat ($urandom_range(0, 5)) @(negedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_newton_steps <= steps;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_operand();
        int          kind;
        logic [31:0] raw;
        kind = $urandom_range(0, 9);
        raw  = $urandom();
        case (kind)
            0, 1, 2, 3: begin
                // Everyday positive numbers, exponents spread around one.
                return {1'b0, 8'($urandom_range(90, 165)), raw[22:0]};
            end
            4: begin
                return {1'b0, 8'($urandom_range(1, 254)), raw[22:0]};
            end
            5: begin
                return {1'b1, 8'($urandom_range(1, 254)), raw[22:0]};
            end
            6: begin
                // Subnormals and signed zeros.
                return {raw[31], 8'd0, (raw[0] ? raw[22:0] : 23'd0)};
            end
            7: begin
                // Infinities and NaNs of both signs.
                return {raw[31], 8'hFF, (raw[1] ? raw[22:0] : 23'd0)};
            end
            default: begin
                return raw;
            end
        endcase
    endfunction

    t_stim_row directed_rows[] = '{
        '{32'h00000000, 1'b0, 32'h0},
        '{32'h80000000, 1'b0, 32'h0},
        '{32'h00000001, 1'b0, 32'h0},
        '{32'h80000001, 1'b0, 32'h0},
        '{32'h007FFFFF, 1'b0, 32'h0},
        '{32'h00800000, 1'b0, 32'h0},
        '{32'h7F7FFFFF, 1'b0, 32'h0},
        '{32'hFF7FFFFF, 1'b0, 32'h0},
        '{32'h7F800000, 1'b0, 32'h0},
        '{32'hFF800000, 1'b0, 32'h0},
        '{32'h7FC00000, 1'b1, CANON_NAN},
        '{32'hFFFFFFFF, 1'b1, CANON_NAN},
        '{32'h7F800001, 1'b1, CANON_NAN},
        '{32'hFF800001, 1'b1, CANON_NAN},
        '{32'h3F800000, 1'b0, 32'h0},
        '{32'h40800000, 1'b0, 32'h0},
        '{32'hBF800000, 1'b0, 32'h0},
        '{32'h3E800000, 1'b0, 32'h0},
        '{32'h5F3759DF, 1'b0, 32'h0},
        '{32'hAAAAAAAA, 1'b0, 32'h0},
        '{32'h55555555, 1'b0, 32'h0}
    };

    logic [1:0] step_plan[] = '{2'd0, 2'd3, 2'd1, 2'd2};

    initial begin
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_operand_bits     = 32'd0;
        i_cfg_valid        = 1'b0;
        i_cfg_newton_steps = 2'd0;
        steps_mirror       = 2'd2;
        mismatch_count     = 0;
        cycle_count        = 0;
        result_count       = 0;
        sent_count         = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table under the reset step count. Typed rows are checked against
        // their literal value too, so a wrong predictor cannot hide a NaN bug.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].typed &&
                rsqrt_predict(directed_rows[r].operand, steps_mirror) !== directed_rows[r].want) begin
                $error("result_bits: expected %h, actual %h (table row %0d)",
                       directed_rows[r].want,
                       rsqrt_predict(directed_rows[r].operand, steps_mirror), r);
                mismatch_count++;
            end
            send_operand(directed_rows[r].operand);
            maybe_idle(1'b0);
        end

        // Random operands under every step count setting.
        foreach (step_plan[p]) begin
            write_steps(step_plan[p]);
            for (int n = 0; n < ITEMS_EACH; n++) begin
                send_operand(random_operand());
                // The first stretch of each phase runs back to back.
                maybe_idle(n < 40);
                // Hold off once mid-phase until the pipeline is empty.
                if (n == ITEMS_EACH / 2) drain_results();
            end
        end

        drain_results();
        repeat (LATENCY + 10) @(negedge i_clk);
        $display("Sent %0d operands and checked %0d results over step counts 2, 0, 3, 1, 2,",
                 sent_count, result_count);
        $display("with zeros, subnormals, infinities, NaNs and negative inputs included.");
        if (mismatch_count == 0 && rsqrt_pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- fast_inverse_square_root.f -----
sv/fisr_pkg.sv
sv/fisr_round.sv
sv/fisr_fmul.sv
sv/fisr_fsub.sv
sv/fast_inverse_square_root.sv
tb/testbench.sv
